### rtl/imapcc_pkg.sv
// ----------------------------------------------------------------------------
// imapcc_pkg
// Keyword table and shared constants for the IMAP command classifier.
// ----------------------------------------------------------------------------
package imapcc_pkg;

  localparam int NKW = 25;
  localparam int KW_MAX = 12;
  localparam logic [4:0] KW_STARTTLS = 5'd1;
  localparam logic [4:0] KW_LOGIN = 5'd4;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_AT = 8'h40;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_K = 8'h4B;

  typedef logic [NKW-1:0] kw_vec_t;

  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd10, 4'd8, 4'd12, 4'd3, 4'd5, 4'd6, 4'd7, 4'd6, 4'd6, 4'd6, 4'd9, 4'd11,
    4'd4, 4'd4, 4'd6, 4'd6, 4'd5, 4'd5, 4'd7, 4'd6, 4'd5, 4'd5, 4'd4, 4'd4, 4'd6
  };

  localparam logic [8*KW_MAX-1:0] KW_TEXT [NKW] = '{
    {"CAPABILITY", 16'h0}, {"STARTTLS", 32'h0}, "AUTHENTICATE",
    {"UID", 72'h0}, {"LOGIN", 56'h0}, {"SELECT", 48'h0}, {"EXAMINE", 40'h0},
    {"CREATE", 48'h0}, {"DELETE", 48'h0}, {"RENAME", 48'h0},
    {"SUBSCRIBE", 24'h0}, {"UNSUBSCRIBE", 8'h0}, {"LIST", 64'h0},
    {"LSUB", 64'h0}, {"STATUS", 48'h0}, {"APPEND", 48'h0}, {"CHECK", 56'h0},
    {"CLOSE", 56'h0}, {"EXPUNGE", 40'h0}, {"SEARCH", 48'h0}, {"FETCH", 56'h0},
    {"STORE", 56'h0}, {"COPY", 64'h0}, {"NOOP", 64'h0}, {"LOGOUT", 48'h0}
  };

  function automatic kw_vec_t kw_filter(kw_vec_t vec, logic [3:0] off, logic [7:0] b);
    kw_vec_t r;
    r = vec;
    for (int k = 0; k < NKW; k++) begin
      if (off < KW_LEN[k] &&
          KW_TEXT[k][8*KW_MAX-1-8*off -: 8] != b)
        r[k] = 1'b0;
    end
    return r;
  endfunction

endpackage

### rtl/imap_command_classifier_top.sv
// ----------------------------------------------------------------------------
// imap_command_classifier_top
// Per-flow IMAP keyword matcher, LOGIN argument parser and STARTTLS tracker.
// ----------------------------------------------------------------------------
// channel | direction | handshake       | payload
// in      | input     | in_valid/stall  | data_byte, first/last_of_packet, from_client
// out     | output    | out_valid/stall | cmd_*, starttls_set, tls_switch, login/domain
// One byte per cycle while in_stall is low; parse state updates in the accept cycle.
// A result is registered on the last byte and shown the next cycle.
// in_stall rises only while a result is held under out_stall and another
// last byte is presented.
// Synchronous reset clears parse state, the STARTTLS flag and out_valid.
// ----------------------------------------------------------------------------
module imap_command_classifier_top
  import imapcc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_of_packet,
  input  logic        last_of_packet,
  input  logic        from_client,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        cmd_valid,
  output logic [4:0]  cmd_code,
  output logic        starttls_set,
  output logic        tls_switch,
  output logic        login_bogus,
  output logic [10:0] user_len,
  output logic        has_domain,
  output logic [10:0] domain_start,
  output logic [10:0] domain_len
);

  localparam int PW = $clog2(MAX_PAYLOAD + 1) + 1;

  logic [PW-1:0] pos, tag_end, arg_start, at_pos, sp_pos;
  logic          tag_done, at_seen, sp_seen, tls_pending;
  logic [1:0]    ok_prog;
  kw_vec_t       m_start, m_tag;

  logic [PW-1:0] pos_next, tag_end_next, arg_start_next, at_pos_next, sp_pos_next;
  logic          tag_done_next, at_seen_next, sp_seen_next, tls_pending_next;
  logic [1:0]    ok_prog_next;
  kw_vec_t       m_start_next, m_tag_next;

  logic          accept, fire;
  logic [PW-1:0] p0, te0, as0, ap0, sp0, off, len, region;
  logic          td0, ats0, sps0;
  logic [1:0]    ok0;
  kw_vec_t       ms0, mt0, vec;
  logic          win_found;
  logic [4:0]    win;

  logic        r_cmd_valid, r_starttls, r_tls_sw, r_bogus, r_has_dom;
  logic [4:0]  r_code;
  logic [10:0] r_user_len, r_dom_start, r_dom_len;

  assign in_stall = out_valid && out_stall && last_of_packet;
  assign accept   = in_valid && !in_stall;
  assign fire     = accept && last_of_packet;

  function automatic logic [1:0] ok_step(logic [PW-1:0] o, logic [1:0] cur, logic [7:0] b);
    logic [1:0] r;
    r = cur;
    if (o == '0) r = (b == CH_O) ? 2'd1 : 2'd0;
    else if (o == PW'(1)) r = (cur == 2'd1 && b == CH_K) ? 2'd2 : 2'd0;
    return r;
  endfunction

  always_comb begin
    p0 = first_of_packet ? '0 : pos;
    te0 = first_of_packet ? '0 : tag_end;
    as0 = first_of_packet ? '0 : arg_start;
    ap0 = first_of_packet ? '0 : at_pos;
    sp0 = first_of_packet ? '0 : sp_pos;
    td0 = first_of_packet ? 1'b0 : tag_done;
    ats0 = first_of_packet ? 1'b0 : at_seen;
    sps0 = first_of_packet ? 1'b0 : sp_seen;
    ok0 = first_of_packet ? 2'd0 : ok_prog;
    ms0 = first_of_packet ? '1 : m_start;
    mt0 = first_of_packet ? '1 : m_tag;

    pos_next = p0; tag_end_next = te0; arg_start_next = as0; at_pos_next = ap0;
    sp_pos_next = sp0; tag_done_next = td0; at_seen_next = ats0; sp_seen_next = sps0;
    ok_prog_next = ok0; m_start_next = ms0; m_tag_next = mt0;
    off = p0 - te0 - PW'(1);

    if (p0 < PW'(MAX_PAYLOAD)) begin
      if (!td0) begin
        if (p0 < PW'(KW_MAX)) m_start_next = kw_filter(ms0, p0[3:0], data_byte);
        ok_prog_next = ok_step(p0, ok0, data_byte);
        if (data_byte == CH_SPACE) begin
          tag_done_next = 1'b1;
          tag_end_next = p0;
          arg_start_next = p0 + PW'(7);
          ok_prog_next = 2'd0;
        end
      end else begin
        if (off < PW'(KW_MAX)) m_tag_next = kw_filter(mt0, off[3:0], data_byte);
        ok_prog_next = ok_step(off, ok0, data_byte);
        if (p0 >= as0) begin
          if (data_byte == CH_AT && !ats0) begin
            at_seen_next = 1'b1; at_pos_next = p0;
          end
          if (data_byte == CH_SPACE && !sps0) begin
            sp_seen_next = 1'b1; sp_pos_next = p0;
          end
        end
      end
      pos_next = p0 + PW'(1);
    end

    len = pos_next;
    vec = tag_done_next ? m_tag_next : m_start_next;
    region = tag_done_next ? (len - tag_end_next - PW'(1)) : len;
    win_found = 1'b0;
    win = '0;
    for (int k = NKW - 1; k >= 0; k--) begin
      if (vec[k] && PW'(KW_LEN[k]) <= region) begin
        win_found = 1'b1; win = 5'(k);
      end
    end

    tls_pending_next = tls_pending;
    r_cmd_valid = 1'b0; r_code = '0; r_starttls = 1'b0; r_tls_sw = 1'b0;
    r_bogus = 1'b0; r_user_len = '0; r_has_dom = 1'b0; r_dom_start = '0; r_dom_len = '0;
    if (from_client) begin
      if (win_found) begin
        r_cmd_valid = 1'b1;
        r_code = win;
        if (win == KW_STARTTLS) begin
          r_starttls = 1'b1;
          tls_pending_next = 1'b1;
        end else if (win == KW_LOGIN) begin
          if (!tag_done_next || arg_start_next > len || !sp_seen_next) begin
            r_bogus = 1'b1;
          end else begin
            r_user_len = 11'(sp_pos_next - arg_start_next);
            if (at_seen_next && at_pos_next < sp_pos_next) begin
              r_has_dom = 1'b1;
              r_dom_start = 11'(at_pos_next + PW'(1));
              r_dom_len = 11'(sp_pos_next - at_pos_next - PW'(1));
            end
          end
        end
      end
    end else if (tls_pending && ok_prog_next == 2'd2) begin
      r_tls_sw = 1'b1;
      tls_pending_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; tag_end <= '0; arg_start <= '0; at_pos <= '0; sp_pos <= '0;
      tag_done <= 1'b0; at_seen <= 1'b0; sp_seen <= 1'b0; ok_prog <= 2'd0;
      m_start <= '1; m_tag <= '1; tls_pending <= 1'b0;
    end else if (accept) begin
      if (last_of_packet) begin
        pos <= '0; tag_end <= '0; arg_start <= '0; at_pos <= '0; sp_pos <= '0;
        tag_done <= 1'b0; at_seen <= 1'b0; sp_seen <= 1'b0; ok_prog <= 2'd0;
        m_start <= '1; m_tag <= '1; tls_pending <= tls_pending_next;
      end else begin
        pos <= pos_next; tag_end <= tag_end_next; arg_start <= arg_start_next;
        at_pos <= at_pos_next; sp_pos <= sp_pos_next; tag_done <= tag_done_next;
        at_seen <= at_seen_next; sp_seen <= sp_seen_next; ok_prog <= ok_prog_next;
        m_start <= m_start_next; m_tag <= m_tag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cmd_valid <= r_cmd_valid; cmd_code <= r_code; starttls_set <= r_starttls;
      tls_switch <= r_tls_sw; login_bogus <= r_bogus; user_len <= r_user_len;
      has_domain <= r_has_dom; domain_start <= r_dom_start; domain_len <= r_dom_len;
    end
  end

`ifndef NO_ASSERTIONS
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cmd_code <= 5'd24)) else $error("code out of range");
  a_tls_clear: assert property (@(posedge clk) disable iff (rst)
    (fire && r_tls_sw) |=> !tls_pending) else $error("pending flag kept");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(tls_switch && cmd_valid)) else $error("server and client result");
  a_login: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (login_bogus || has_domain)) |-> (cmd_valid && cmd_code == KW_LOGIN))
    else $error("login fields without login");
`endif

endmodule

### sim/imapcc_checker.sv
// ----------------------------------------------------------------------------
// imapcc_checker
// Watches both channels of the IMAP command classifier, predicts each packet
// result from the accepted bytes and compares each result word with the prediction.
// ----------------------------------------------------------------------------
module imapcc_checker
  import imapcc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 2048
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_of_packet,
  input  logic        last_of_packet,
  input  logic        from_client,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        cmd_valid,
  input  logic [4:0]  cmd_code,
  input  logic        starttls_set,
  input  logic        tls_switch,
  input  logic        login_bogus,
  input  logic [10:0] user_len,
  input  logic        has_domain,
  input  logic [10:0] domain_start,
  input  logic [10:0] domain_len,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        cmd_valid;
    logic [4:0]  cmd_code;
    logic        starttls_set;
    logic        tls_switch;
    logic        login_bogus;
    logic [10:0] user_len;
    logic        has_domain;
    logic [10:0] domain_start;
    logic [10:0] domain_len;
  } verdict_t;

  localparam string KW_STR [NKW] = '{
    "CAPABILITY", "STARTTLS", "AUTHENTICATE", "UID", "LOGIN", "SELECT",
    "EXAMINE", "CREATE", "DELETE", "RENAME", "SUBSCRIBE", "UNSUBSCRIBE",
    "LIST", "LSUB", "STATUS", "APPEND", "CHECK", "CLOSE", "EXPUNGE",
    "SEARCH", "FETCH", "STORE", "COPY", "NOOP", "LOGOUT"
  };

  verdict_t verdict_q[$];

  int      pos, tag_pos, arg_pos, at_pos, sp_pos, ok_stage;
  bit      in_cmd, at_seen, sp_seen, tls_armed;
  kw_vec_t head_live, cmd_live;

  function automatic kw_vec_t prune(kw_vec_t v, int off, logic [7:0] b);
    for (int k = 0; k < NKW; k++)
      if (off < KW_STR[k].len() && KW_STR[k][off] != b) v[k] = 1'b0;
    return v;
  endfunction

  task automatic clear_parse();
    pos = 0; tag_pos = 0; arg_pos = 0; at_pos = 0; sp_pos = 0; ok_stage = 0;
    in_cmd = 0; at_seen = 0; sp_seen = 0;
    head_live = '1; cmd_live = '1;
  endtask

  task automatic advance_ok(int off, logic [7:0] b);
    if (off == 0) ok_stage = (b == CH_O) ? 1 : 0;
    else if (off == 1) ok_stage = (ok_stage == 1 && b == CH_K) ? 2 : 0;
  endtask

  task automatic classify_byte(logic [7:0] b, bit first, bit last, bit client);
    verdict_t v;
    kw_vec_t  live;
    int       span, off;
    if (first) clear_parse();
    if (pos < MAX_PAYLOAD) begin
      if (!in_cmd) begin
        head_live = prune(head_live, pos, b);
        advance_ok(pos, b);
        if (b == CH_SPACE) begin
          in_cmd = 1; tag_pos = pos; arg_pos = pos + 7; ok_stage = 0;
        end
      end else begin
        off = pos - tag_pos - 1;
        cmd_live = prune(cmd_live, off, b);
        advance_ok(off, b);
        if (pos >= arg_pos) begin
          if (b == CH_AT && !at_seen) begin at_seen = 1; at_pos = pos; end
          if (b == CH_SPACE && !sp_seen) begin sp_seen = 1; sp_pos = pos; end
        end
      end
      pos++;
    end
    if (!last) return;
    v = '0;
    if (client) begin
      live = in_cmd ? cmd_live : head_live;
      span = in_cmd ? pos - tag_pos - 1 : pos;
      for (int k = 0; k < NKW; k++) begin
        if (live[k] && KW_STR[k].len() <= span) begin
          v.cmd_valid = 1; v.cmd_code = k[4:0];
          break;
        end
      end
      if (v.cmd_valid && v.cmd_code == KW_STARTTLS) begin
        v.starttls_set = 1; tls_armed = 1;
      end else if (v.cmd_valid && v.cmd_code == KW_LOGIN) begin
        if (!in_cmd || arg_pos > pos || !sp_seen) v.login_bogus = 1;
        else begin
          v.user_len = 11'(sp_pos - arg_pos);
          if (at_seen && at_pos < sp_pos) begin
            v.has_domain = 1;
            v.domain_start = 11'(at_pos + 1);
            v.domain_len = 11'(sp_pos - at_pos - 1);
          end
        end
      end
    end else if (tls_armed && ok_stage == 2) begin
      v.tls_switch = 1; tls_armed = 0;
    end
    verdict_q.push_back(v);
    clear_parse();
  endtask

  always @(posedge clk) begin
    verdict_t got, want;
    if (rst) begin
      clear_parse();
      tls_armed = 0;
      verdict_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{cmd_valid, cmd_code, starttls_set, tls_switch, login_bogus,
                user_len, has_domain, domain_start, domain_len};
        if (verdict_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        classify_byte(data_byte, first_of_packet, last_of_packet, from_client);
    end
    pending_count <= verdict_q.size();
  end
endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random IMAP packets byte by byte into the classifier
// with random gaps and receiver stalls, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAYLOAD_MAX = 64;

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [7:0]  data_byte = 0;
  logic        first_of_packet = 0, last_of_packet = 0, from_client = 0;
  logic        cmd_valid, starttls_set, tls_switch, login_bogus, has_domain;
  logic [4:0]  cmd_code;
  logic [10:0] user_len, domain_start, domain_len;
  int          fail_count, pending_count, idle_cycles;
  bit          stim_done = 0;
  byte         pkt[$];
  int          sent = 0;

  localparam string CMD_WORDS [25] = '{
    "CAPABILITY", "STARTTLS", "AUTHENTICATE", "UID", "LOGIN", "SELECT",
    "EXAMINE", "CREATE", "DELETE", "RENAME", "SUBSCRIBE", "UNSUBSCRIBE",
    "LIST", "LSUB", "STATUS", "APPEND", "CHECK", "CLOSE", "EXPUNGE",
    "SEARCH", "FETCH", "STORE", "COPY", "NOOP", "LOGOUT"
  };
  localparam string ALPHABET = "AaZz09@ .OKLGIN";

  always #5 clk = ~clk;

  imap_command_classifier_top #(.MAX_PAYLOAD(PAYLOAD_MAX)) dut (.*);
  imapcc_checker #(.MAX_PAYLOAD(PAYLOAD_MAX)) chk (.*);

  always @(negedge clk) out_stall <= ($urandom_range(0, 3) == 0) && !stim_done;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("** imap_command_classifier_top: FAILED **");
      $finish;
    end
  end

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) pkt.push_back(s[i]);
  endtask

  task automatic push_noise(int n);
    for (int i = 0; i < n; i++)
      pkt.push_back($urandom_range(0, 1) ? ALPHABET[$urandom_range(0, 14)]
                                         : byte'($urandom_range(0, 255)));
  endtask

  // send pkt as one packet; odd framing on request
  task automatic send_packet(bit client, bit mark_first = 1, bit mix_dir = 0);
    for (int i = 0; i < pkt.size(); i++) begin
      if (sent > 0 && $urandom_range(0, 7) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
      in_valid <= 1;
      data_byte <= pkt[i];
      first_of_packet <= (i == 0) && mark_first;
      last_of_packet <= (i == pkt.size() - 1);
      from_client <= (i == pkt.size() - 1) ? client : (mix_dir ? $urandom_range(0, 1) : client);
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
      sent++;
    end
    in_valid <= 0;
    pkt.delete();
  endtask

  task automatic login_packet();
    push_str("a1 LOGIN ");
    push_noise($urandom_range(0, 4));
    if ($urandom_range(0, 1)) pkt.push_back("@");
    push_noise($urandom_range(0, 4));
    if ($urandom_range(0, 4) != 0) pkt.push_back(" ");
    push_noise($urandom_range(0, 4));
  endtask

  initial begin
    int kind;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed
    foreach (CMD_WORDS[k]) begin
      push_str(CMD_WORDS[k]); send_packet(1);
    end
    push_str("OK x"); send_packet(0);
    push_str("t STARTTLS"); send_packet(1);
    push_str("t O"); send_packet(0);
    push_str("t OK go"); send_packet(0);
    push_str("t LOGI"); send_packet(1);
    push_str("LOGIN"); send_packet(1);
    push_str("x LOGIN"); send_packet(1);
    push_str("x LOGIN u@dom pw"); send_packet(1);
    push_str("x LOGIN  u@dom"); send_packet(1);
    push_str("x LOGIN user pw"); send_packet(1);
    push_str("CAPABILITY"); send_packet(1);
    pkt.push_back(8'hFF); pkt.push_back(8'h00); send_packet(1);
    push_str("t NOOP"); send_packet(1, 0);
    push_str("t LIST"); send_packet(1, 1, 1);
    for (int i = 0; i < PAYLOAD_MAX + 6; i++)
      pkt.push_back(i < 5 ? "x" : (i == 5 ? " " : "A"));
    push_str("Z"); send_packet(1);
    push_str("t LOGIN "); for (int i = 0; i < PAYLOAD_MAX - 4; i++) pkt.push_back("u");
    send_packet(1);
    // random
    while (sent < 460) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        if ($urandom_range(0, 1)) push_str("tg ");
        push_str(CMD_WORDS[$urandom_range(0, 24)]);
        if ($urandom_range(0, 3) == 0) void'(pkt.pop_back());
        push_noise($urandom_range(0, 5));
        send_packet(1, $urandom_range(0, 9) != 0, $urandom_range(0, 4) == 0);
      end else if (kind < 5) begin
        login_packet(); send_packet(1);
      end else if (kind < 7) begin
        push_str("s STARTTLS"); send_packet(1);
        if ($urandom_range(0, 1)) push_str("s "); push_str("OK");
        if ($urandom_range(0, 2) == 0) void'(pkt.pop_back());
        push_noise($urandom_range(0, 3)); send_packet(0);
      end else begin
        push_noise($urandom_range(1, 12));
        send_packet($urandom_range(0, 1), $urandom_range(0, 3) != 0);
      end
    end
    stim_done = 1;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("** imap_command_classifier_top: PASSED **");
    else $display("** imap_command_classifier_top: FAILED **");
    $finish;
  end
endmodule
